// File: hdl/sma_pkg.sv
`timescale 1ns / 1ps
// Shared types, codes and constants of the square matrix arithmetic core.
package sma_pkg;

  localparam int unsigned DATA_W = 32;
  localparam int unsigned IDX_W = 2;
  localparam int unsigned MODE_W = 2;
  localparam int unsigned ACC_W = 64;
  localparam int unsigned DIM_DEF = 4;
  localparam int unsigned FRAC_BITS_DEF = 16;

  // Configuration register indexes.
  localparam logic REG_OP_MODE = 1'b0;
  localparam logic REG_SCALE = 1'b1;

  localparam logic [MODE_W-1:0] OP_MODE_RESET = 2'd2;
  localparam logic [DATA_W-1:0] SCALE_RESET = 32'h0001_0000;

  typedef enum logic [MODE_W-1:0] {
    MODE_ADD   = 2'd0,
    MODE_SUB   = 2'd1,
    MODE_MUL   = 2'd2,
    MODE_SCALE = 2'd3
  } op_mode_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] a_value;
    logic signed [DATA_W-1:0] b_value;
  } in_beat_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] result_value;
    logic [IDX_W-1:0]         row_index;
    logic [IDX_W-1:0]         col_index;
    logic                     saturated;
    logic                     last_element;
  } out_beat_t;

  // Controller to datapath.
  typedef struct packed {
    logic     load_we;     // store one element pair
    logic     capture;     // sample the scalar register
    logic     rd_en;       // read one operand pair
    logic     first_term;  // restart the accumulator
    logic     last_term;   // final term of this element
    logic     last_elem;   // final element of the matrix
    op_mode_e mode;
  } dp_cmd_t;

  // Datapath to controller.
  typedef struct packed {
    logic done;  // final result beat is on the output this cycle
  } dp_status_t;

endpackage

// File: hdl/square_matrix_arithmetic_core.sv
`timescale 1ns / 1ps
// Top level of the square matrix arithmetic core: register file and unit wiring.
//
//  Channel   Handshake                  Payload            Direction
//  -------   -------------------------  -----------------  ---------
//  load      start high, busy low       in_beat_i          in
//  result    res_valid_o strobe, 1 cyc  res_beat_o         out
//  config    APB psel/penable/pwrite    paddr/pwdata       in/out
//
// Loading accepts one beat per cycle while busy is low. The completing beat raises busy;
// product mode then needs DIM^3 operand reads, the other modes DIM^2 reads, as
// set by one read port per store and one shared multiplier.
// Product mode gives one result beat per DIM terms, the others one beat a cycle.
// Reset clears control state and the registers; the stores hold no reset.
// The receiver cannot stall: each result beat stands for exactly one cycle.
module square_matrix_arithmetic_core #(
  parameter int unsigned DIM = sma_pkg::DIM_DEF,
  parameter int unsigned FRAC_BITS = sma_pkg::FRAC_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // load channel
  input  logic                          start,
  output logic                          busy,
  input  sma_pkg::in_beat_t             in_beat_i,
  // result channel
  output logic                          res_valid_o,
  output sma_pkg::out_beat_t            res_beat_o,
  // configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [sma_pkg::DATA_W-1:0]    pwdata,
  output logic [sma_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);

  localparam int unsigned CELLS = DIM * DIM;
  localparam int unsigned CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1;
  localparam int unsigned DIM_W = (DIM > 1) ? $clog2(DIM) : 1;

  sma_pkg::op_mode_e op_mode_q;
  logic signed [sma_pkg::DATA_W-1:0] scale_q;
  logic reg_wr;
  logic reg_sel;

  sma_pkg::dp_cmd_t cmd;
  sma_pkg::dp_status_t status;
  logic [CELL_AW-1:0] wr_addr, rd_addr_a, rd_addr_b;
  logic [DIM_W-1:0] row, col;

  // Register file: word index sits at paddr[2]; byte offset is ignored.
  assign pready = 1'b1;
  assign reg_sel = paddr[2];
  assign reg_wr = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_mode_q <= sma_pkg::op_mode_e'(sma_pkg::OP_MODE_RESET);
      scale_q <= sma_pkg::SCALE_RESET;
    end else if (reg_wr) begin
      case (reg_sel)
        sma_pkg::REG_OP_MODE: op_mode_q <= sma_pkg::op_mode_e'(pwdata[sma_pkg::MODE_W-1:0]);
        sma_pkg::REG_SCALE:   scale_q <= pwdata;
        default:              scale_q <= scale_q;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      sma_pkg::REG_OP_MODE: prdata = sma_pkg::DATA_W'(op_mode_q);
      sma_pkg::REG_SCALE:   prdata = scale_q;
      default:              prdata = '0;
    endcase
  end

  // Sequencer: counts load beats, then walks every result element and term.
  sma_ctrl #(
    .DIM(DIM)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .op_mode_i  (op_mode_q),
    .status_i   (status),
    .busy_o     (busy),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_a_o(rd_addr_a),
    .rd_addr_b_o(rd_addr_b),
    .row_o      (row),
    .col_o      (col)
  );

  // Datapath: holds both matrices, multiplies, accumulates and saturates.
  sma_datapath #(
    .DIM      (DIM),
    .FRAC_BITS(FRAC_BITS)
  ) u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .wr_addr_i  (wr_addr),
    .rd_addr_a_i(rd_addr_a),
    .rd_addr_b_i(rd_addr_b),
    .row_i      (row),
    .col_i      (col),
    .beat_i     (in_beat_i),
    .scale_i    (scale_q),
    .status_o   (status),
    .res_valid_o(res_valid_o),
    .res_beat_o (res_beat_o)
  );

endmodule

// File: hdl/sma_ctrl.sv
`timescale 1ns / 1ps
// Controller: load counter, compute sequencer and address generation.
module sma_ctrl #(
  parameter int unsigned DIM = sma_pkg::DIM_DEF,
  localparam int unsigned CELLS = DIM * DIM,
  localparam int unsigned CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1,
  localparam int unsigned DIM_W = (DIM > 1) ? $clog2(DIM) : 1
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  sma_pkg::op_mode_e    op_mode_i,
  input  sma_pkg::dp_status_t  status_i,
  output logic                 busy_o,
  output sma_pkg::dp_cmd_t     cmd_o,
  output logic [CELL_AW-1:0]   wr_addr_o,
  output logic [CELL_AW-1:0]   rd_addr_a_o,
  output logic [CELL_AW-1:0]   rd_addr_b_o,
  output logic [DIM_W-1:0]     row_o,
  output logic [DIM_W-1:0]     col_o
);

  typedef enum logic [2:0] {
    ST_LOAD  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } ctrl_state_e;

  ctrl_state_e state_q, state_d;
  sma_pkg::op_mode_e mode_q, mode_d;
  logic [CELL_AW-1:0] ld_cnt_q, ld_cnt_d;
  logic [DIM_W-1:0] i_q, i_d, j_q, j_d, k_q, k_d;
  logic load_we, load_done, is_mul, last_term, last_elem, last_issue;

  assign busy_o = (state_q != ST_LOAD);
  assign load_we = (state_q == ST_LOAD) && start_i;
  assign load_done = load_we && (ld_cnt_q == CELL_AW'(CELLS - 1));
  assign is_mul = (mode_q == sma_pkg::MODE_MUL);
  assign last_term = !is_mul || (k_q == DIM_W'(DIM - 1));
  assign last_elem = (i_q == DIM_W'(DIM - 1)) && (j_q == DIM_W'(DIM - 1));
  assign last_issue = last_term && last_elem;

  always_comb begin
    state_d = state_q;
    mode_d = mode_q;
    ld_cnt_d = ld_cnt_q;
    i_d = i_q;
    j_d = j_q;
    k_d = k_q;
    case (state_q)
      ST_LOAD: begin
        if (load_done) begin
          ld_cnt_d = '0;
          mode_d = op_mode_i;
          i_d = '0;
          j_d = '0;
          k_d = '0;
          state_d = ST_ISSUE;
        end else if (load_we) begin
          ld_cnt_d = ld_cnt_q + CELL_AW'(1);
        end
      end
      ST_ISSUE: begin
        if (last_term) begin
          k_d = '0;
          if (j_q == DIM_W'(DIM - 1)) begin
            j_d = '0;
            i_d = i_q + DIM_W'(1);
          end else begin
            j_d = j_q + DIM_W'(1);
          end
        end else begin
          k_d = k_q + DIM_W'(1);
        end
        if (last_issue) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (status_i.done) begin
          state_d = ST_LOAD;
        end
      end
      default: begin
        state_d = ST_LOAD;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      mode_q <= sma_pkg::MODE_MUL;
      ld_cnt_q <= '0;
      i_q <= '0;
      j_q <= '0;
      k_q <= '0;
    end else begin
      state_q <= state_d;
      mode_q <= mode_d;
      ld_cnt_q <= ld_cnt_d;
      i_q <= i_d;
      j_q <= j_d;
      k_q <= k_d;
    end
  end

  always_comb begin
    cmd_o.load_we = load_we;
    cmd_o.capture = load_done;
    cmd_o.rd_en = (state_q == ST_ISSUE);
    cmd_o.first_term = !is_mul || (k_q == '0);
    cmd_o.last_term = last_term;
    cmd_o.last_elem = last_elem;
    cmd_o.mode = mode_q;
  end

  assign wr_addr_o = ld_cnt_q;
  assign row_o = i_q;
  assign col_o = j_q;
  // Product mode walks row i of A and column j of B; element-wise modes read cell (i, j).
  assign rd_addr_a_o = CELL_AW'(i_q) * CELL_AW'(DIM) + (is_mul ? CELL_AW'(k_q) : CELL_AW'(j_q));
  assign rd_addr_b_o = is_mul ? (CELL_AW'(k_q) * CELL_AW'(DIM) + CELL_AW'(j_q))
                              : (CELL_AW'(i_q) * CELL_AW'(DIM) + CELL_AW'(j_q));

`ifndef SYNTHESIS
  a_no_result_while_loading: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_LOAD) |-> !status_i.done)
    else $error("result beat while loading");
  a_capture_starts_issue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.capture |=> (state_q == ST_ISSUE) && (i_q == '0) && (j_q == '0) && (k_q == '0))
    else $error("compute did not start from the first element");
`endif

endmodule

// File: hdl/sma_datapath.sv
`timescale 1ns / 1ps
// Datapath: matrix stores, shared multiplier, accumulator and saturation.
module sma_datapath #(
  parameter int unsigned DIM = sma_pkg::DIM_DEF,
  parameter int unsigned FRAC_BITS = sma_pkg::FRAC_BITS_DEF,
  localparam int unsigned CELLS = DIM * DIM,
  localparam int unsigned CELL_AW = (CELLS > 1) ? $clog2(CELLS) : 1,
  localparam int unsigned DIM_W = (DIM > 1) ? $clog2(DIM) : 1
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  sma_pkg::dp_cmd_t                    cmd_i,
  input  logic [CELL_AW-1:0]                  wr_addr_i,
  input  logic [CELL_AW-1:0]                  rd_addr_a_i,
  input  logic [CELL_AW-1:0]                  rd_addr_b_i,
  input  logic [DIM_W-1:0]                    row_i,
  input  logic [DIM_W-1:0]                    col_i,
  input  sma_pkg::in_beat_t                   beat_i,
  input  logic signed [sma_pkg::DATA_W-1:0]   scale_i,
  output sma_pkg::dp_status_t                 status_o,
  output logic                                res_valid_o,
  output sma_pkg::out_beat_t                  res_beat_o
);

  localparam int unsigned DW = sma_pkg::DATA_W;
  localparam int unsigned AW = sma_pkg::ACC_W;

  typedef struct packed {
    logic                first_term;
    logic                last_term;
    logic                last_elem;
    logic                is_mul;
    sma_pkg::op_mode_e   mode;
    logic [DIM_W-1:0]    row;
    logic [DIM_W-1:0]    col;
  } tag_t;

  logic [DW-1:0] store_a_q [CELLS];
  logic [DW-1:0] store_b_q [CELLS];
  logic signed [DW-1:0] a_rd_q, b_rd_q, scale_q;

  logic s1_v_q, s2_v_q, s3_v_q;
  tag_t s1_tag_q, s2_tag_q, s3_tag_q, s0_tag;

  logic signed [DW-1:0] op_x;
  logic signed [AW-1:0] term_d, term_q, term_s, acc_d, acc_q;
  logic clip;
  logic [DIM_W+1:0] row_ext, col_ext;

  logic res_valid_q;
  sma_pkg::out_beat_t res_q, res_d;

  // Element stores: one write port for loading, one registered read port each.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_we) begin
      store_a_q[wr_addr_i] <= beat_i.a_value;
      store_b_q[wr_addr_i] <= beat_i.b_value;
    end
    if (cmd_i.rd_en) begin
      a_rd_q <= store_a_q[rd_addr_a_i];
      b_rd_q <= store_b_q[rd_addr_b_i];
    end
    if (cmd_i.capture) begin
      scale_q <= scale_i;
    end
  end

  always_comb begin
    s0_tag.first_term = cmd_i.first_term;
    s0_tag.last_term = cmd_i.last_term;
    s0_tag.last_elem = cmd_i.last_elem;
    s0_tag.is_mul = (cmd_i.mode == sma_pkg::MODE_MUL) || (cmd_i.mode == sma_pkg::MODE_SCALE);
    s0_tag.mode = cmd_i.mode;
    s0_tag.row = row_i;
    s0_tag.col = col_i;
  end

  // Stage 1 to 2: one multiplier shared by product and scale modes.
  assign op_x = (s1_tag_q.mode == sma_pkg::MODE_SCALE) ? scale_q : a_rd_q;

  always_comb begin
    case (s1_tag_q.mode)
      sma_pkg::MODE_ADD: term_d = AW'(a_rd_q) + AW'(b_rd_q);
      sma_pkg::MODE_SUB: term_d = AW'(a_rd_q) - AW'(b_rd_q);
      default:           term_d = AW'(op_x) * AW'(b_rd_q);
    endcase
  end

  // Stage 2 to 3: truncate products toward minus infinity, then accumulate.
  assign term_s = s2_tag_q.is_mul ? (term_q >>> FRAC_BITS) : term_q;
  assign acc_d = s2_tag_q.first_term ? term_s : (acc_q + term_s);

  always_ff @(posedge clk_i) begin
    if (s1_v_q) begin
      term_q <= term_d;
    end
    if (s2_v_q) begin
      acc_q <= acc_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
      s1_tag_q <= '0;
      s2_tag_q <= '0;
      s3_tag_q <= '0;
    end else begin
      s1_v_q <= cmd_i.rd_en;
      s2_v_q <= s1_v_q;
      s3_v_q <= s2_v_q;
      s1_tag_q <= s0_tag;
      s2_tag_q <= s1_tag_q;
      s3_tag_q <= s2_tag_q;
    end
  end

  // Stage 3 to output: saturate the finished sum to 32 bits.
  assign clip = !((&acc_q[AW-1:DW-1]) || !(|acc_q[AW-1:DW-1]));
  assign row_ext = (DIM_W + 2)'(s3_tag_q.row);
  assign col_ext = (DIM_W + 2)'(s3_tag_q.col);

  always_comb begin
    res_d.saturated = clip;
    if (clip) begin
      res_d.result_value = acc_q[AW-1] ? {1'b1, {(DW - 1){1'b0}}} : {1'b0, {(DW - 1){1'b1}}};
    end else begin
      res_d.result_value = acc_q[DW-1:0];
    end
    res_d.row_index = row_ext[sma_pkg::IDX_W-1:0];
    res_d.col_index = col_ext[sma_pkg::IDX_W-1:0];
    res_d.last_element = s3_tag_q.last_elem;
  end

  always_ff @(posedge clk_i) begin
    if (s3_v_q && s3_tag_q.last_term) begin
      res_q <= res_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= s3_v_q && s3_tag_q.last_term;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_beat_o = res_q;
  assign status_o.done = res_valid_q && res_q.last_element;

`ifndef SYNTHESIS
  a_sat_is_extreme: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_q && res_q.saturated) |->
      (res_q.result_value == 32'sh7fff_ffff || res_q.result_value == 32'sh8000_0000))
    else $error("saturated beat not at a range limit");
  a_load_when_drained: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.load_we |-> !(s1_v_q || s2_v_q || s3_v_q || res_valid_q))
    else $error("store written while compute in flight");
`endif

endmodule

// File: test/testbench.sv
`timescale 1ns / 1ps
// Self-checking testbench of the square matrix arithmetic core.
module testbench;
  import sma_pkg::*;

  localparam int unsigned N = DIM_DEF;
  localparam int unsigned CELLS = N * N;
  localparam int unsigned FRAC = FRAC_BITS_DEF;
  localparam int unsigned CLK_HALF = 4;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned RANDOM_LOADS = 250;
  // Pipeline is four deep; leave headroom for a load beat still being stored.
  localparam int unsigned SETTLE_CYCLES = 16;
  localparam longint SAT_HI = 64'sd2147483647;
  localparam longint SAT_LO = -64'sd2147483647 - 64'sd1;

  // Corner values of a Q16.16 element: both extremes, zero, -1 lsb, +-1.0,
  // one lsb and 1.5.
  localparam logic [DATA_W-1:0] CORNER [8] = '{
    32'h7fff_ffff, 32'h8000_0000, 32'h0000_0000, 32'hffff_ffff,
    32'h0001_0000, 32'hffff_0000, 32'h0000_0001, 32'h0001_8000
  };

  // Mirrors the core: keeps its own copy of both element stores, the fill
  // count and the two registers, and queues the result beats each completed
  // matrix pair must produce.
  class matrix_result_tracker;
    int          a_cells [CELLS];
    int          b_cells [CELLS];
    int unsigned fill;
    op_mode_e    mode;
    int          scale;
    out_beat_t   pending_elements [$];
    int unsigned mismatches;

    function new();
      fill = 0;
      mode = op_mode_e'(OP_MODE_RESET);
      scale = SCALE_RESET;
      mismatches = 0;
    endfunction

    function void set_reg(logic idx, logic [DATA_W-1:0] value);
      if (idx == REG_OP_MODE) begin
        mode = op_mode_e'(value[MODE_W-1:0]);
      end else begin
        scale = value;
      end
    endfunction

    // Full 64-bit product, floored by the arithmetic shift.
    function longint fixed_mul(int x, int y);
      longint p;
      p = longint'(x) * longint'(y);
      return p >>> FRAC;
    endfunction

    function void note_load(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b);
      longint    acc;
      out_beat_t e;
      int        c;
      a_cells[fill] = a;
      b_cells[fill] = b;
      fill++;
      if (fill < CELLS) return;
      fill = 0;
      for (int r = 0; r < N; r++) begin
        for (int col = 0; col < N; col++) begin
          c = r * N + col;
          case (mode)
            MODE_ADD: acc = longint'(a_cells[c]) + longint'(b_cells[c]);
            MODE_SUB: acc = longint'(a_cells[c]) - longint'(b_cells[c]);
            MODE_MUL: begin
              // Sum the truncated products exactly, clip once at the end.
              acc = 0;
              for (int k = 0; k < N; k++) begin
                acc += fixed_mul(a_cells[r * N + k], b_cells[k * N + col]);
              end
            end
            default: acc = fixed_mul(scale, b_cells[c]);
          endcase
          e.saturated = 1'b1;
          if (acc > SAT_HI) begin
            acc = SAT_HI;
          end else if (acc < SAT_LO) begin
            acc = SAT_LO;
          end else begin
            e.saturated = 1'b0;
          end
          e.result_value = acc[DATA_W-1:0];
          e.row_index = IDX_W'(r);
          e.col_index = IDX_W'(col);
          e.last_element = (c == CELLS - 1);
          pending_elements.push_back(e);
        end
      end
    endfunction

    function void compare_field(string name, logic [DATA_W-1:0] want, logic [DATA_W-1:0] got);
      if (got !== want) begin
        $display("%0t: %s mismatch: expected %h, actual %h", $time, name, want, got);
        mismatches++;
      end
    endfunction

    function void check_element(out_beat_t got);
      out_beat_t want;
      if (pending_elements.size() == 0) begin
        $display("%0t: unexpected result beat: expected none, actual %h", $time, got);
        mismatches++;
        return;
      end
      want = pending_elements.pop_front();
      compare_field("result_value", want.result_value, got.result_value);
      compare_field("row_index", DATA_W'(want.row_index), DATA_W'(got.row_index));
      compare_field("col_index", DATA_W'(want.col_index), DATA_W'(got.col_index));
      compare_field("saturated", DATA_W'(want.saturated), DATA_W'(got.saturated));
      compare_field("last_element", DATA_W'(want.last_element), DATA_W'(got.last_element));
    endfunction
  endclass

  logic              clk_i = 1'b0;
  logic              rst_ni;
  logic              start;
  logic              busy;
  in_beat_t          in_beat;
  logic              res_valid_o;
  out_beat_t         res_beat_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  matrix_result_tracker results = new();

  square_matrix_arithmetic_core u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .busy       (busy),
    .in_beat_i  (in_beat),
    .res_valid_o(res_valid_o),
    .res_beat_o (res_beat_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  always #(CLK_HALF) clk_i = ~clk_i;

  // The receiver cannot stall: take every strobed result beat at the edge
  // that closes its cycle.
  always @(posedge clk_i) begin
    if (rst_ni === 1'b1 && res_valid_o === 1'b1) begin
      results.check_element(res_beat_o);
    end
  end

  // Offer one element pair and hold it until a rising edge sees busy low.
  // Without a burst, drop start for a random gap first; in a burst keep it
  // high so back-to-back beats stream.
  task automatic load_pair(logic [DATA_W-1:0] a, logic [DATA_W-1:0] b, bit burst);
    int unsigned gap;
    gap = burst ? 0 : $urandom_range(0, 6);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start <= 1'b1;
    in_beat <= '{a_value: a, b_value: b};
    do @(posedge clk_i); while (busy);
    results.note_load(a, b);
  endtask

  // APB write: setup phase, access phase until pready, then back to idle.
  task automatic write_reg(logic idx, logic [DATA_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    results.set_reg(idx, value);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk_i);
  endtask

  // Advance until every queued result beat has come, then let the pipeline
  // settle.
  task automatic wait_drained();
    while (results.pending_elements.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  // Spread 0 keeps elements mostly within +-4.0 so products stay exact;
  // higher spreads mix in full-range words that drive saturation.
  function automatic logic [DATA_W-1:0] draw_element(int unsigned spread);
    int unsigned pick;
    pick = $urandom_range(0, 9);
    if (pick < spread * 3) return $urandom;
    if (pick == 9) return CORNER[$urandom_range(0, 7)];
    return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
  endfunction

  // Scalar: the extremes and zero first, then a mix of full-range words, small
  // values, reciprocals (division by 1..16) and unity.
  function automatic logic [DATA_W-1:0] draw_scale(int unsigned phase);
    logic [DATA_W-1:0] recip;
    case (phase)
      1: return 32'h7fff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h0000_0000;
      default: begin
        recip = 32'(32'h0001_0000 / $urandom_range(1, 16));
        case ($urandom_range(0, 3))
          0: return $urandom;
          1: return $urandom_range(0, 32'h0008_0000) - 32'h0004_0000;
          2: return $urandom_range(0, 1) ? recip : -recip;
          default: return SCALE_RESET;
        endcase
      end
    endcase
  endfunction

  initial begin
    int unsigned loaded;
    int unsigned phase;
    int unsigned count;
    int unsigned spread;
    bit          burst;
    op_mode_e    mode;

    rst_ni <= 1'b0;
    start <= 1'b0;
    in_beat <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset registers select the matrix product: feed corner values so rows
    // and columns of extremes clip both ways beside exact small terms.
    for (int k = 0; k < CELLS; k++) begin
      load_pair(CORNER[k % 8], CORNER[(k * 3 + 1) % 8], 1'b0);
    end
    start <= 1'b0;
    wait_drained();

    // Switch to subtract half way through a load; junk in the upper bits of
    // the write must be dropped. The mode counts at the completing beat.
    for (int k = 0; k < CELLS / 2; k++) begin
      load_pair(CORNER[k % 8], CORNER[(k + 1) % 8], 1'b0);
    end
    start <= 1'b0;
    wait_drained();
    write_reg(REG_OP_MODE, 32'hffff_fffc | 32'(MODE_SUB));
    for (int k = CELLS / 2; k < CELLS; k++) begin
      load_pair(CORNER[k % 8], CORNER[(k + 1) % 8], 1'b1);
    end
    start <= 1'b0;

    // Random phases. The first four load whole matrices in scale mode: the
    // reset scalar, then both extremes and zero. After that, phases end at
    // random points so register writes also land in the middle of a load.
    loaded = 0;
    phase = 0;
    while (loaded < RANDOM_LOADS) begin
      wait_drained();
      if (phase < 4) begin
        mode = MODE_SCALE;
      end else if (phase == 4) begin
        mode = MODE_ADD;
      end else begin
        mode = op_mode_e'($urandom_range(0, 3));
      end
      write_reg(REG_OP_MODE, ($urandom & ~32'h3) | 32'(mode));
      if (phase > 0 && (phase < 4 || $urandom_range(0, 1) == 1)) begin
        write_reg(REG_SCALE, draw_scale(phase));
      end
      count = (phase < 4) ? CELLS : $urandom_range(1, 40);
      spread = (phase < 4) ? phase % 3 : $urandom_range(0, 2);
      burst = ($urandom_range(0, 3) == 0);
      for (int k = 0; k < count; k++) begin
        load_pair(draw_element(spread), draw_element(spread), burst);
      end
      start <= 1'b0;
      loaded += count;
      phase++;
    end

    wait_drained();
    if (results.mismatches == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog: end the run as a failure if it never finishes.
  initial begin
    #2_000_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule
